FILE: design/pst_pkg.sv
package pst_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASSIFY,
    S_DIV,
    S_NEXT,
    S_CHECK,
    S_SQRT,
    S_FINISH
  } state_t;

  // which trial divisor the last remainder belongs to
  typedef enum logic [1:0] {
    PH_THREE,
    PH_LOW,
    PH_HIGH
  } phase_t;

  // result of the shared compare-subtract unit
  typedef struct packed {
    logic ge;
  } cmp_flags_t;

  localparam int DIV_THREE = 3;
  localparam int DIV_FIVE  = 5;
  localparam int DIV_STEP  = 6;
  localparam int PAIR_GAP  = 2;

endpackage

FILE: design/prime_sqrt_transform.sv
// Primality test and square-root transform, one value per beat.
//
// Input channel: value, last with in_valid; the block raises in_stall while it
// works on a value, so one value is in flight at a time. Output channel:
// result_fixed, was_prime, last_out with out_valid; out_stall holds the beat in
// the output register, and the sequencer waits for that register to drain
// before it writes the next result. The next value is taken as soon as the
// result is written, even while that result still waits to be taken.
//
// Sequence: trial division, bound checks and square-root steps all go through
// one compare-subtract unit. A remainder is built one dividend bit per step
// and then decided in S_NEXT, and each pair of 6k-1, 6k+1 divisors adds one
// bound check in S_CHECK. 0, 1 and even values other than 2 go straight from
// classification to the output register; odd multiples of 3 other than 3 end
// after the first remainder; a prime near 2^31 runs through up to about 15000
// trial divisors and then the square root, one root bit per step.
//
// Reset (rst, synchronous) returns the sequencer to idle and empties the
// output register; no result survives it.
module prime_sqrt_transform #(
  parameter int VALUE_BITS    = 31,
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [VALUE_BITS-1:0]             value,
  input  logic                              last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [VALUE_BITS+FRACTION_BITS-1:0] result_fixed,
  output logic                              was_prime,
  output logic                              last_out
);

  localparam int HALF_BITS  = (VALUE_BITS + 1) / 2;
  localparam int PAIR_COUNT = HALF_BITS + FRACTION_BITS;
  localparam int RAD_BITS   = 2 * PAIR_COUNT;
  localparam int D_BITS     = HALF_BITS + 1;
  localparam int SQ_BITS    = 2 * D_BITS;
  localparam int ROOT_REM   = PAIR_COUNT + 3;
  localparam int UNIT_BITS  = (SQ_BITS > ROOT_REM) ? SQ_BITS : ROOT_REM;
  localparam int OUT_BITS   = VALUE_BITS + FRACTION_BITS;
  localparam int MAX_ITER   = (VALUE_BITS > PAIR_COUNT) ? VALUE_BITS : PAIR_COUNT;
  localparam int CNT_BITS   = $clog2(MAX_ITER);

  pst_pkg::state_t state, state_next;
  pst_pkg::phase_t phase;

  logic [VALUE_BITS-1:0] n;
  logic                  last_r;
  logic [D_BITS-1:0]     d;
  logic [SQ_BITS-1:0]    sq;
  logic [D_BITS-1:0]     divisor;
  logic [VALUE_BITS-1:0] dividend;
  logic [RAD_BITS-1:0]   rad;
  logic [UNIT_BITS-1:0]  rem;
  logic [PAIR_COUNT-1:0] root;
  logic [CNT_BITS-1:0]   cnt;
  logic                  prime;

  logic [UNIT_BITS-1:0]  unit_a;
  logic [UNIT_BITS-1:0]  unit_b;
  logic [UNIT_BITS-1:0]  unit_diff;
  pst_pkg::cmp_flags_t   unit_flags;
  logic [UNIT_BITS-1:0]  unit_keep;

  logic n_small;
  logic n_two_three;
  logic out_free;
  logic accept;

  assign n_small     = (n[VALUE_BITS-1:1] == '0);
  assign n_two_three = (n[VALUE_BITS-1:2] == '0) && n[1];
  assign out_free    = ~out_valid | ~out_stall;
  assign accept      = in_valid & ~in_stall;
  assign unit_keep   = unit_flags.ge ? unit_diff : unit_a;

  pst_cmpsub #(
    .UNIT_BITS(UNIT_BITS)
  ) u_cmpsub (
    .a    (unit_a),
    .b    (unit_b),
    .diff (unit_diff),
    .flags(unit_flags)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pst_pkg::S_IDLE: begin
        if (in_valid) state_next = pst_pkg::S_CLASSIFY;
      end
      pst_pkg::S_CLASSIFY: begin
        priority if (n_small) state_next = pst_pkg::S_FINISH;
        else if (n_two_three) state_next = pst_pkg::S_SQRT;
        else if (!n[0]) state_next = pst_pkg::S_FINISH;
        else state_next = pst_pkg::S_DIV;
      end
      pst_pkg::S_DIV: begin
        if (cnt == '0) state_next = pst_pkg::S_NEXT;
      end
      pst_pkg::S_NEXT: begin
        priority if (rem == '0) state_next = pst_pkg::S_FINISH;
        else if (phase == pst_pkg::PH_LOW) state_next = pst_pkg::S_DIV;
        else state_next = pst_pkg::S_CHECK;
      end
      pst_pkg::S_CHECK: begin
        state_next = unit_flags.ge ? pst_pkg::S_DIV : pst_pkg::S_SQRT;
      end
      pst_pkg::S_SQRT: begin
        if (cnt == '0) state_next = pst_pkg::S_FINISH;
      end
      pst_pkg::S_FINISH: begin
        if (out_free) state_next = pst_pkg::S_IDLE;
      end
      default: state_next = pst_pkg::S_IDLE;
    endcase
  end

  // stall and operand select for the shared unit
  always_comb begin
    in_stall = (state != pst_pkg::S_IDLE);
    unit_a   = '0;
    unit_b   = '0;
    unique case (state)
      pst_pkg::S_DIV: begin
        unit_a = (rem << 1) | UNIT_BITS'(dividend[VALUE_BITS-1]);
        unit_b = UNIT_BITS'(divisor);
      end
      pst_pkg::S_CHECK: begin
        unit_a = UNIT_BITS'(n);
        unit_b = UNIT_BITS'(sq);
      end
      pst_pkg::S_SQRT: begin
        unit_a = (rem << 2) | UNIT_BITS'(rad[RAD_BITS-1 -: 2]);
        unit_b = (UNIT_BITS'(root) << 2) | UNIT_BITS'(1);
      end
      default: begin
        unit_a = '0;
        unit_b = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pst_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == pst_pkg::S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      pst_pkg::S_IDLE: begin
        if (accept) begin
          n      <= value;
          last_r <= last;
        end
      end
      pst_pkg::S_CLASSIFY: begin
        prime    <= n_two_three;
        phase    <= pst_pkg::PH_THREE;
        divisor  <= D_BITS'(pst_pkg::DIV_THREE);
        dividend <= n;
        rem      <= '0;
        // 2 and 3 go straight to the square root, other odd values above 1 to division by 3
        cnt      <= n_two_three ? CNT_BITS'(PAIR_COUNT - 1) : CNT_BITS'(VALUE_BITS - 1);
        rad      <= RAD_BITS'(n) << (2 * FRACTION_BITS);
        root     <= '0;
      end
      pst_pkg::S_DIV: begin
        rem      <= unit_keep;
        dividend <= dividend << 1;
        cnt      <= cnt - CNT_BITS'(1);
      end
      pst_pkg::S_NEXT: begin
        prime    <= 1'b0;
        dividend <= n;
        rem      <= '0;
        cnt      <= CNT_BITS'(VALUE_BITS - 1);
        unique case (phase)
          pst_pkg::PH_THREE: begin
            d     <= D_BITS'(pst_pkg::DIV_FIVE);
            sq    <= SQ_BITS'(pst_pkg::DIV_FIVE * pst_pkg::DIV_FIVE);
            phase <= pst_pkg::PH_LOW;
          end
          pst_pkg::PH_LOW: begin
            divisor <= d + D_BITS'(pst_pkg::PAIR_GAP);
            phase   <= pst_pkg::PH_HIGH;
          end
          pst_pkg::PH_HIGH: begin
            // (d + 6)^2 = d^2 + 12d + 36
            d     <= d + D_BITS'(pst_pkg::DIV_STEP);
            sq    <= sq + (SQ_BITS'(d) << 3) + (SQ_BITS'(d) << 2)
                     + SQ_BITS'(pst_pkg::DIV_STEP * pst_pkg::DIV_STEP);
            phase <= pst_pkg::PH_LOW;
          end
          default: phase <= pst_pkg::PH_LOW;
        endcase
      end
      pst_pkg::S_CHECK: begin
        divisor <= d;
        prime   <= ~unit_flags.ge;
        rem     <= '0;
        root    <= '0;
        rad     <= RAD_BITS'(n) << (2 * FRACTION_BITS);
        cnt     <= unit_flags.ge ? CNT_BITS'(VALUE_BITS - 1) : CNT_BITS'(PAIR_COUNT - 1);
      end
      pst_pkg::S_SQRT: begin
        rem  <= unit_keep;
        root <= {root[PAIR_COUNT-2:0], unit_flags.ge};
        rad  <= rad << 2;
        cnt  <= cnt - CNT_BITS'(1);
      end
      pst_pkg::S_FINISH: begin
        if (out_free) begin
          result_fixed <= prime ? OUT_BITS'(root) : (OUT_BITS'(n) << FRACTION_BITS);
          was_prime    <= prime;
          last_out     <= last_r;
        end
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

endmodule

FILE: design/pst_cmpsub.sv
module pst_cmpsub #(
  parameter int UNIT_BITS = 48
) (
  input  logic [UNIT_BITS-1:0] a,
  input  logic [UNIT_BITS-1:0] b,
  output logic [UNIT_BITS-1:0] diff,
  output pst_pkg::cmp_flags_t  flags
);

  logic [UNIT_BITS:0] wide;

  // subtract with borrow out; no borrow means a >= b
  assign wide     = {1'b0, a} - {1'b0, b};
  assign diff     = wide[UNIT_BITS-1:0];
  assign flags.ge = ~wide[UNIT_BITS];

endmodule

FILE: design/pst_check.sv
module pst_check #(
  parameter int VALUE_BITS    = 31,
  parameter int FRACTION_BITS = 16
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [VALUE_BITS+FRACTION_BITS-1:0] result_fixed,
  input logic                                was_prime,
  input logic                                last_out
);

  localparam int PAIR_COUNT = (VALUE_BITS + 1) / 2 + FRACTION_BITS;

  // a stalled beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  // a stalled beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(result_fixed) && $stable(was_prime)
                               && $stable(last_out))
    else $error("output payload changed while stalled");

  // the block works on one value at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a value is in flight");

  // a square root never reaches past the root width
  a_root_width: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_prime |-> (result_fixed >> PAIR_COUNT) == '0)
    else $error("prime result wider than its square root");

  // a passed-through value has no fraction bits
  a_pass_fraction: assert property (@(posedge clk) disable iff (rst)
    out_valid && !was_prime |-> (result_fixed << VALUE_BITS) == '0)
    else $error("non-prime result carries fraction bits");

endmodule

bind prime_sqrt_transform pst_check #(
  .VALUE_BITS   (VALUE_BITS),
  .FRACTION_BITS(FRACTION_BITS)
) u_pst_check (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .result_fixed(result_fixed),
  .was_prime   (was_prime),
  .last_out    (last_out)
);

FILE: tb/tb_prime_sqrt_transform.sv
module tb_prime_sqrt_transform;

  localparam int VALUE_W     = 31;
  localparam int FRAC_W      = 16;
  localparam int RESULT_W    = VALUE_W + FRAC_W;
  localparam int ROOT_PAIRS  = (VALUE_W + 1) / 2 + FRAC_W;
  // one prime near 2^31 runs through about 15000 trial divisors on its own
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [RESULT_W-1:0] scaled;
    logic                prime;
    logic                marker;
  } transform_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [VALUE_W-1:0]  value     = '0;
  logic                last      = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [RESULT_W-1:0] result_fixed;
  logic                was_prime;
  logic                last_out;

  transform_t  pending_results[$];
  transform_t  head_result;
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  // receiver stall control: the test bumps hold_ticket to request a long hold
  bit          rx_random   = 1'b1;
  int unsigned hold_ticket = 0;
  int unsigned hold_len    = 0;
  int unsigned hold_seen   = 0;
  int unsigned stall_left  = 0;

  prime_sqrt_transform u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_fixed (result_fixed),
    .was_prime    (was_prime),
    .last_out     (last_out)
  );

  always #5 clk = ~clk;

  // trial division by 2, 3 and then 6k-1, 6k+1 up to the square root
  function automatic bit is_prime_trial(input longint unsigned n);
    longint unsigned d;
    if (n < 2) return 1'b0;
    if (n == 2 || n == 3) return 1'b1;
    if (n % 2 == 0 || n % 3 == 0) return 1'b0;
    for (d = 5; d * d <= n; d += 6) begin
      if (n % d == 0 || n % (d + 2) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // floor(sqrt(n) * 2^FRAC_W), two radicand bits per step
  function automatic logic [RESULT_W-1:0] fixed_root(input longint unsigned n);
    longint unsigned radicand;
    longint unsigned rem;
    longint unsigned root;
    longint unsigned trial;
    int i;
    radicand = n << (2 * FRAC_W);
    rem = 0;
    root = 0;
    for (i = ROOT_PAIRS - 1; i >= 0; i--) begin
      rem   = (rem << 2) | ((radicand >> (2 * i)) & 64'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[RESULT_W-1:0];
  endfunction

  function automatic transform_t predict_transform(input logic [VALUE_W-1:0] v,
                                                   input logic l);
    transform_t t;
    t.prime  = is_prime_trial(longint'(v));
    t.scaled = t.prime ? fixed_root(longint'(v)) : ({{FRAC_W{1'b0}}, v} << FRAC_W);
    t.marker = l;
    return t;
  endfunction

  // mostly small values; large ones only with a small factor to keep runs short
  function automatic logic [VALUE_W-1:0] draw_value();
    int unsigned pick;
    int unsigned f;
    pick = $urandom_range(99);
    if (pick < 45) return VALUE_W'($urandom_range(4095));
    if (pick < 60) return VALUE_W'($urandom_range(1 << 18, 4096));
    if (pick < 85) return VALUE_W'($urandom() & 32'h7FFF_FFFE);
    f = $urandom_range(61, 3) | 1;
    return VALUE_W'(f * $urandom_range(32'h7FFF_FFFF / f, 1));
  endfunction

  function automatic logic draw_last();
    return ($urandom_range(7) == 0);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return 0;
    if (r < 88) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // offer one beat and hold it until the block takes it
  task automatic send_value(input logic [VALUE_W-1:0] v, input logic l);
    @(negedge clk);
    in_valid <= 1'b1;
    value    <= v;
    last     <= l;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_transform(v, l));
  endtask

  task automatic sender_idle(input int unsigned n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_for_results();
    sender_idle(1);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // zero, one, small primes, squares of 6k+-1 primes and the field extremes
  task automatic test_corner_values();
    int unsigned corner [20] = '{
      0, 1, 2, 3, 4, 5, 6, 7, 9, 25, 35, 49, 97, 121, 65521,
      1073741824, 2147483643, 2147483645, 2147483646, 2147483647
    };
    rx_random = 1'b1;
    foreach (corner[i]) send_value(VALUE_W'(corner[i]), (i % 4 == 3) || (i == 19));
    sender_idle(1);
  endtask

  task automatic test_random_traffic();
    int unsigned g;
    rx_random = 1'b1;
    repeat (60) begin
      send_value(draw_value(), draw_last());
      g = pick_gap();
      if (g > 0) sender_idle(g);
    end
    sender_idle(1);
  endtask

  // no gaps on either side
  task automatic test_back_to_back();
    rx_random = 1'b0;
    repeat (20) send_value(draw_value(), draw_last());
    sender_idle(1);
    rx_random = 1'b1;
  endtask

  // hold the output for a long stretch while quick values keep coming
  task automatic test_output_backpressure();
    rx_random = 1'b0;
    hold_len  = 300;
    hold_ticket++;
    repeat (6) send_value(VALUE_W'($urandom_range(200)), draw_last());
    sender_idle(1);
    rx_random = 1'b1;
  endtask

  // pause the sender until every pending result is back
  task automatic test_pause_until_empty();
    repeat (2) begin
      repeat (6) send_value(draw_value(), draw_last());
      wait_for_results();
    end
  endtask

  // drive the receiver stall: short bursts mostly, a few long ones
  always @(negedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen  = hold_ticket;
      stall_left = hold_len;
    end else if (stall_left == 0 && rx_random && $urandom_range(3) == 0) begin
      stall_left = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each accepted result beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: result_fixed=%0d was_prime=%0b last_out=%0b",
               result_fixed, was_prime, last_out);
        fail_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (result_fixed !== head_result.scaled) begin
          $error("result_fixed: expected %0d, got %0d", head_result.scaled, result_fixed);
          fail_count++;
        end
        if (was_prime !== head_result.prime) begin
          $error("was_prime: expected %0b, got %0b", head_result.prime, was_prime);
          fail_count++;
        end
        if (last_out !== head_result.marker) begin
          $error("last_out: expected %0b, got %0b", head_result.marker, last_out);
          fail_count++;
        end
      end
    end
  end

  // abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_corner_values();
    test_random_traffic();
    test_back_to_back();
    test_output_backpressure();
    test_pause_until_empty();
    wait_for_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
